### rtl/mcp_pkg.sv
`timescale 1ns / 1ps
package mcp_pkg;

    localparam int LAYERS    = 4;
    localparam int VERTICES  = 256;
    localparam int WORDS     = VERTICES / 64;
    localparam int KREGS     = 4;

    localparam int LAYER_W   = 2;
    localparam int VERT_W    = 8;
    localparam int WORD_W    = 2;
    localparam int DEG_W     = 9;
    localparam int CNT_W     = 9;

    localparam int ADJ_DEPTH = LAYERS * VERTICES * WORDS;
    localparam int DEG_DEPTH = LAYERS * VERTICES;
    localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
    localparam int DEG_AW    = $clog2(DEG_DEPTH);

    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_COMPUTE = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [LAYER_W-1:0] layer;
        logic [VERT_W-1:0]  vertex;
        logic [VERT_W-1:0]  neighbor;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_index;
        logic [63:0]       member_bits;
        logic [CNT_W-1:0]  member_count;
        logic              last_word;
    } out_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_ADD,
        S_COPY,
        S_QRD,
        S_QDAT,
        S_ROW,
        S_SCAN,
        S_DEC,
        S_EMIT
    } state_t;

endpackage

### rtl/mcp_ram.sv
`timescale 1ns / 1ps
module mcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/multilayer_core_peeling.sv
`timescale 1ns / 1ps
// Adjacency entry: a row read, then a conditional row and degree write.
// Clear request: clears one adjacency row word per cycle; the same pass runs after reset.
// Compute: copies the degrees, then per peeled vertex and layer scans every row word and updates
// each surviving neighbour, then gives WORDS result transactions, one a cycle unless m_ready stalls.
// The peeling cost is set by the single read port of the adjacency and working-degree memories.
// Reset is synchronous; no input is taken until the clearing pass has finished.
module multilayer_core_peeling
    import mcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t state_reg, state_next;

    logic [DEG_W-1:0]    k_reg [KREGS];
    logic [VERTICES-1:0] removed_reg, removed_next;
    logic [CNT_W-1:0]    head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]    round_end_reg, round_end_next, j_reg, j_next;
    logic [LAYER_W-1:0]  layer_reg, layer_next;
    logic [VERT_W-1:0]   v_reg, v_next, u_reg, u_next;
    logic [WORD_W-1:0]   w_reg, w_next;
    logic [63:0]         pend_reg, pend_next;
    logic [ADJ_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [DEG_AW:0]     cp_cnt_reg, cp_cnt_next;
    logic                cpv_reg, cpv_next;
    logic [DEG_AW-1:0]   cpa_reg, cpa_next;
    in_t                 add_reg, add_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;

    logic              adj_we, ld_we, wk_we, q_we;
    logic [ADJ_AW-1:0] adj_waddr, adj_raddr;
    logic [63:0]       adj_wdata, adj_rdata;
    logic [DEG_AW-1:0] ld_waddr, ld_raddr, wk_waddr, wk_raddr;
    logic [DEG_W-1:0]  ld_wdata, ld_rdata, wk_wdata, wk_rdata;
    logic [VERT_W-1:0] q_raddr, q_rdata;

    logic              push_en;
    logic [VERT_W-1:0] push_v;
    logic              s_fire;
    logic [63:0]       low_bit, add_bit, rem_word;
    logic [5:0]        low_idx;
    logic [DEG_W-1:0]  dec_val;

    mcp_ram #(.WIDTH(64), .DEPTH(ADJ_DEPTH)) u_adj (
        .aclk(aclk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );
    mcp_ram #(.WIDTH(DEG_W), .DEPTH(DEG_DEPTH)) u_loaded (
        .aclk(aclk), .we(ld_we), .waddr(ld_waddr), .wdata(ld_wdata),
        .raddr(ld_raddr), .rdata(ld_rdata)
    );
    mcp_ram #(.WIDTH(DEG_W), .DEPTH(DEG_DEPTH)) u_working (
        .aclk(aclk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
        .raddr(wk_raddr), .rdata(wk_rdata)
    );
    mcp_ram #(.WIDTH(VERT_W), .DEPTH(VERTICES)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(tail_reg[VERT_W-1:0]), .wdata(push_v),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {{(32-DEG_W){1'b0}}, k_reg[paddr[3:2]]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KREGS; i++) begin
                k_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            k_reg[paddr[3:2]] <= pwdata[DEG_W-1:0];
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Lowest pending neighbour in the current row word.
    assign low_bit  = pend_reg & (~pend_reg + 64'd1);
    assign add_bit  = 64'd1 << add_reg.neighbor[5:0];
    assign rem_word = removed_reg[64*w_reg +: 64];
    assign dec_val  = wk_rdata - DEG_W'(1);

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < 64; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | 6'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            cpv_reg     <= 1'b0;
            removed_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cpv_reg     <= cpv_next;
            removed_reg <= removed_next;
        end
        round_end_reg <= round_end_next;
        j_reg         <= j_next;
        layer_reg     <= layer_next;
        v_reg         <= v_next;
        u_reg         <= u_next;
        w_reg         <= w_next;
        pend_reg      <= pend_next;
        cp_cnt_reg    <= cp_cnt_next;
        cpa_reg       <= cpa_next;
        add_reg       <= add_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cpv_next       = 1'b0;
        cpa_next       = cpa_reg;
        cp_cnt_next    = cp_cnt_reg;
        removed_next   = removed_reg;
        round_end_next = round_end_reg;
        j_next         = j_reg;
        layer_next     = layer_reg;
        v_next         = v_reg;
        u_next         = u_reg;
        w_next         = w_reg;
        pend_next      = pend_reg;
        add_next       = add_reg;

        adj_we    = 1'b0;
        adj_waddr = {add_reg.layer, add_reg.vertex, add_reg.neighbor[7:6]};
        adj_wdata = adj_rdata | add_bit;
        adj_raddr = {s_data.layer, s_data.vertex, s_data.neighbor[7:6]};
        ld_we     = 1'b0;
        ld_waddr  = {add_reg.layer, add_reg.vertex};
        ld_wdata  = ld_rdata + DEG_W'(1);
        ld_raddr  = {s_data.layer, s_data.vertex};
        wk_we     = 1'b0;
        wk_waddr  = {layer_reg, u_reg};
        wk_wdata  = dec_val;
        wk_raddr  = {layer_reg, w_reg, low_idx};
        q_raddr   = j_reg[VERT_W-1:0];
        push_en   = 1'b0;
        push_v    = u_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                adj_we       = 1'b1;
                adj_waddr    = clr_cnt_reg;
                adj_wdata    = '0;
                ld_we        = 1'b1;
                ld_waddr     = clr_cnt_reg[ADJ_AW-1:WORD_W];
                ld_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + ADJ_AW'(1);
                if (clr_cnt_reg == {ADJ_AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                add_next = s_data;
                if (s_fire) begin
                    case (s_data.req_type)
                        REQ_ADD: begin
                            state_next = S_ADD;
                        end
                        REQ_COMPUTE: begin
                            removed_next = '0;
                            head_next    = '0;
                            tail_next    = '0;
                            cp_cnt_next  = '0;
                            state_next   = S_COPY;
                        end
                        REQ_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                // A duplicate entry leaves the row and the degree untouched.
                if ((adj_rdata & add_bit) == 64'd0) begin
                    adj_we = 1'b1;
                    ld_we  = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_COPY: begin
                ld_raddr = cp_cnt_reg[DEG_AW-1:0];
                if (cp_cnt_reg != (DEG_AW+1)'(DEG_DEPTH)) begin
                    cp_cnt_next = cp_cnt_reg + (DEG_AW+1)'(1);
                    cpv_next    = 1'b1;
                    cpa_next    = cp_cnt_reg[DEG_AW-1:0];
                end
                if (cpv_reg) begin
                    wk_we    = 1'b1;
                    wk_waddr = cpa_reg;
                    wk_wdata = ld_rdata;
                    push_v   = cpa_reg[VERT_W-1:0];
                    if (!removed_reg[push_v]
                            && ld_rdata < k_reg[cpa_reg[DEG_AW-1:VERT_W]]) begin
                        push_en = 1'b1;
                    end
                end else if (cp_cnt_reg == (DEG_AW+1)'(DEG_DEPTH)) begin
                    round_end_next = tail_reg;
                    j_next         = head_reg;
                    layer_next     = '0;
                    state_next     = S_QRD;
                end
            end
            S_QRD: begin
                if (j_reg == round_end_reg) begin
                    if (layer_reg == LAYER_W'(LAYERS - 1)) begin
                        head_next = round_end_reg;
                        if (round_end_reg == tail_reg) begin
                            w_next     = '0;
                            state_next = S_EMIT;
                        end else begin
                            round_end_next = tail_reg;
                            j_next         = round_end_reg;
                            layer_next     = '0;
                        end
                    end else begin
                        layer_next = layer_reg + LAYER_W'(1);
                        j_next     = head_reg;
                    end
                end else begin
                    state_next = S_QDAT;
                end
            end
            S_QDAT: begin
                v_next     = q_rdata;
                w_next     = '0;
                adj_raddr  = {layer_reg, q_rdata, {WORD_W{1'b0}}};
                state_next = S_ROW;
            end
            S_ROW: begin
                pend_next  = adj_rdata & ~rem_word;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (pend_reg == 64'd0) begin
                    if (w_reg == WORD_W'(WORDS - 1)) begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_QRD;
                    end else begin
                        w_next     = w_reg + WORD_W'(1);
                        adj_raddr  = {layer_reg, v_reg, w_reg + WORD_W'(1)};
                        state_next = S_ROW;
                    end
                end else begin
                    u_next     = {w_reg, low_idx};
                    pend_next  = pend_reg & ~low_bit;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                // A degree already at zero counts as below every threshold.
                if (wk_rdata == '0) begin
                    push_en = 1'b1;
                end else begin
                    wk_we = 1'b1;
                    if (dec_val < k_reg[layer_reg]) begin
                        push_en = 1'b1;
                    end
                end
                state_next = S_SCAN;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.word_index   = w_reg;
                    m_data_next.member_bits  = ~rem_word;
                    m_data_next.member_count = CNT_W'(VERTICES) - tail_reg;
                    m_data_next.last_word    = (w_reg == WORD_W'(WORDS - 1));
                    w_next                   = w_reg + WORD_W'(1);
                    if (w_reg == WORD_W'(WORDS - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en) begin
            removed_next[push_v] = 1'b1;
            tail_next            = tail_reg + CNT_W'(1);
        end
        q_we = push_en;
    end

    a_tail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg <= CNT_W'(VERTICES))
        else $error("peel queue tail beyond vertex count");

    a_head_le_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg && round_end_reg <= tail_reg || state_reg == S_COPY
        || state_reg == S_IDLE || state_reg == S_CLR || state_reg == S_ADD
        || state_reg == S_EMIT)
        else $error("peel queue pointers out of order");

    a_push_once: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> !removed_reg[push_v])
        else $error("vertex pushed twice");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |=> removed_reg[$past(push_v)] && tail_reg == $past(tail_reg) + CNT_W'(1))
        else $error("push did not mark the vertex or advance the tail");

endmodule

### tb/tb_multilayer_core_peeling.sv
`timescale 1ns / 1ps
class core_scoreboard;
    mcp_pkg::out_t pending[$];
    logic [255:0]  rows[4][256];
    int unsigned   loaded[4][256];
    int unsigned   k_thr[4];
    int            mismatches;

    function new();
        clear_graph();
        foreach (k_thr[i]) k_thr[i] = 0;
        mismatches = 0;
    endfunction

    function void clear_graph();
        for (int l = 0; l < 4; l++)
            for (int v = 0; v < 256; v++) begin
                rows[l][v] = '0;
                loaded[l][v] = 0;
            end
    endfunction

    // Breadth-order peeling; the round structure matters because decrements at
    // zero depend on the order in which removals are applied.
    function void compute_core();
        int unsigned   wdeg[4][256];
        bit            gone[256];
        int unsigned   order[$];
        int unsigned   head, round_end, count, v;
        logic [63:0]   bits;
        mcp_pkg::out_t r;
        head = 0;
        for (int l = 0; l < 4; l++)
            for (int j = 0; j < 256; j++) wdeg[l][j] = loaded[l][j];
        foreach (gone[j]) gone[j] = 0;
        for (int l = 0; l < 4; l++)
            for (int j = 0; j < 256; j++)
                if (!gone[j] && wdeg[l][j] < k_thr[l]) begin
                    gone[j] = 1;
                    order.push_back(j);
                end
        while (head < order.size()) begin
            round_end = order.size();
            for (int l = 0; l < 4; l++)
                for (int q = head; q < round_end; q++) begin
                    v = order[q];
                    for (int u = 0; u < 256; u++) begin
                        if (!rows[l][v][u] || gone[u]) continue;
                        if (wdeg[l][u] == 0) begin
                            gone[u] = 1;
                            order.push_back(u);
                        end else begin
                            wdeg[l][u]--;
                            if (wdeg[l][u] < k_thr[l]) begin
                                gone[u] = 1;
                                order.push_back(u);
                            end
                        end
                    end
                end
            head = round_end;
        end
        count = 0;
        foreach (gone[j]) if (!gone[j]) count++;
        for (int w = 0; w < 4; w++) begin
            for (int b = 0; b < 64; b++) bits[b] = !gone[w*64+b];
            r.word_index   = 2'(w);
            r.member_bits  = bits;
            r.member_count = 9'(count);
            r.last_word    = (w == 3);
            pending.push_back(r);
        end
    endfunction

    function void note_request(mcp_pkg::in_t it);
        case (it.req_type)
            mcp_pkg::REQ_ADD: begin
                if (!rows[it.layer][it.vertex][it.neighbor]) begin
                    rows[it.layer][it.vertex][it.neighbor] = 1'b1;
                    loaded[it.layer][it.vertex]++;
                end
            end
            mcp_pkg::REQ_COMPUTE: compute_core();
            mcp_pkg::REQ_CLEAR:   clear_graph();
            default: ;
        endcase
    endfunction

    function void check_word(mcp_pkg::out_t got);
        mcp_pkg::out_t exp_w;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
        end
        exp_w = pending.pop_front();
        if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected idx %0d bits %h cnt %0d last %0b, got idx %0d bits %h cnt %0d last %0b",
                         exp_w.word_index, exp_w.member_bits, exp_w.member_count,
                         exp_w.last_word, got.word_index, got.member_bits,
                         got.member_count, got.last_word);
        end
    endfunction
endclass

module tb_multilayer_core_peeling;
    import mcp_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_t        m_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    core_scoreboard sb;
    int          send_idle_pct, recv_stall_pct;
    longint      cycle_count = 0;
    localparam longint CYCLE_LIMIT = 60_000_000;

    multilayer_core_peeling u_top (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial sb = new();

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (aresetn && m_valid && m_ready) sb.check_word(m_data);
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_threshold(input int idx, input int value);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 4'(idx * 4); pwdata <= 32'(value);
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.k_thr[idx] = value;
    endtask

    task automatic send_request(input in_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid <= 1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(it);
        @(negedge aclk);
        s_valid <= 0;
    endtask

    task automatic send_fields(input logic [1:0] rq, input int l, input int v, input int n);
        in_t it;
        it.req_type = rq; it.layer = 2'(l); it.vertex = 8'(v); it.neighbor = 8'(n);
        send_request(it);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Adds an undirected edge in one layer, as two adjacency transactions.
    task automatic add_edge(input int l, input int a, input int b);
        send_fields(REQ_ADD, l, a, b);
        send_fields(REQ_ADD, l, b, a);
    endtask

    task automatic random_phase(input int n_items, input int spread);
        int r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 80)
                add_edge($urandom_range(3), $urandom_range(spread - 1),
                         $urandom_range(spread - 1));
            else if (r < 88)
                send_fields(REQ_ADD, $urandom_range(3), $urandom_range(255),
                            $urandom_range(255));
            else if (r < 96)
                send_fields(REQ_COMPUTE, $urandom_range(3), $urandom_range(255),
                            $urandom_range(255));
            else if (r < 98)
                send_fields(REQ_CLEAR, $urandom_range(3), $urandom_range(255),
                            $urandom_range(255));
            else
                send_fields(2'd3, $urandom_range(3), $urandom_range(255),
                            $urandom_range(255));
        end
        send_fields(REQ_COMPUTE, 0, 0, 0);
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: empty graph with zero thresholds keeps every vertex.
        send_fields(REQ_COMPUTE, 3, 8'hFF, 8'hFF);
        add_edge(0, 0, 255);
        add_edge(3, 255, 128);
        send_fields(REQ_ADD, 0, 0, 255);     // duplicate entry
        send_fields(REQ_ADD, 1, 7, 9);       // one-sided row
        send_fields(2'd3, 2, 100, 200);      // unused code
        send_fields(REQ_COMPUTE, 0, 0, 0);
        drain();
        write_threshold(0, 1);
        write_threshold(1, 0);
        write_threshold(2, 0);
        write_threshold(3, 0);
        send_fields(REQ_COMPUTE, 2, 5, 6);
        drain();
        // Asymmetric row makes a decrement at zero possible.
        write_threshold(0, 0);
        write_threshold(1, 1);
        send_fields(REQ_COMPUTE, 0, 0, 0);
        drain();
        write_threshold(0, 256);
        write_threshold(1, 256);
        write_threshold(2, 256);
        write_threshold(3, 256);
        send_fields(REQ_COMPUTE, 0, 0, 0);
        drain();
        send_fields(REQ_CLEAR, 1, 2, 3);
        send_fields(REQ_COMPUTE, 0, 0, 0);
        drain();

        // Random phases across idling patterns and thresholds.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            write_threshold(0, $urandom_range(3));
            write_threshold(1, $urandom_range(2));
            write_threshold(2, ph == 3 ? 0 : $urandom_range(2));
            write_threshold(3, ph == 0 ? 256 : $urandom_range(1));
            send_fields(REQ_CLEAR, 0, 0, 0);
            random_phase(20, 16 + ph * 40);
            drain();
            random_phase(29, 256);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### filelist.f
rtl/mcp_pkg.sv
rtl/mcp_ram.sv
rtl/multilayer_core_peeling.sv
tb/tb_multilayer_core_peeling.sv
